// File: hdl/interval_range_table_assert.svh
// Assertion macros shared by the interval range table RTL.
`ifndef INTERVAL_RANGE_TABLE_ASSERT_SVH
`define INTERVAL_RANGE_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while rst is high.
`define IRT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while rst is high.
`define IRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/irt_pkg.sv
// Package with the sizes, types and codes of the interval range table.
`timescale 1ns / 1ps
`default_nettype none

package irt_pkg;

  localparam int TableDepth = 64;
  localparam int KeyBits    = 32;
  localparam int ValueBits  = 8;
  localparam int CountBits  = $clog2(TableDepth + 1);
  localparam int PassBits   = $clog2(TableDepth);
  localparam int StatusBits = 2;

  typedef logic [KeyBits-1:0]   key_t;
  typedef logic [ValueBits-1:0] value_t;
  typedef logic [CountBits-1:0] count_t;

  typedef enum logic {
    CMD_ASSIGN = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic [StatusBits-1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // One breakpoint as held by a cell of the ring.
  typedef struct packed {
    logic   valid;
    key_t   key;
    value_t value;
  } entry_t;

  // Control shared by every cell of the ring.
  typedef struct packed {
    logic   shift;
    logic   clear;
    value_t seed_value;
  } ring_ctl_t;

endpackage

`default_nettype wire

// File: hdl/irt_if.sv
// Channel interfaces of the interval range table: commands, results and configuration.
`timescale 1ns / 1ps
`default_nettype none

interface irt_req_if import irt_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   command;
  key_t   key_begin;
  key_t   key_end;
  value_t new_value;
  key_t   query_key;

  modport source (
    output valid, command, key_begin, key_end, new_value, query_key,
    input  ready
  );
  modport sink (
    input  valid, command, key_begin, key_end, new_value, query_key,
    output ready
  );
endinterface

interface irt_rsp_if import irt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  value_t                found_value;
  logic [StatusBits-1:0] status;
  count_t                entries_used;

  modport source (
    output valid, found_value, status, entries_used,
    input  ready
  );
  modport sink (
    input  valid, found_value, status, entries_used,
    output ready
  );
endinterface

interface irt_cfg_if import irt_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t initial_value;

  modport source (
    output valid, initial_value,
    input  ready
  );
  modport sink (
    input  valid, initial_value,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/irt_cell.sv
// One storage cell of the breakpoint ring.
`timescale 1ns / 1ps
`default_nettype none

module irt_cell import irt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  ring_ctl_t ctl,
  input  logic      seed,
  input  entry_t    d,
  output entry_t    q
);

  // The seed cell holds the breakpoint at key zero after reset or a rebuild.
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '{valid: seed, key: '0, value: '0};
    end else if (ctl.clear) begin
      q <= '{valid: seed, key: '0, value: ctl.seed_value};
    end else if (ctl.shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/irt_ctrl.sv
// Sequencer that scans and rewrites the breakpoint ring and owns the handshakes.
`timescale 1ns / 1ps
`default_nettype none

`include "interval_range_table_assert.svh"

module irt_ctrl import irt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  irt_req_if.sink   req,
  irt_rsp_if.source rsp,
  irt_cfg_if.sink   cfg,
  input  entry_t    ring_out,
  output entry_t    ring_in,
  output ring_ctl_t ctl
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_WRITE  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t                state;
  logic [PassBits-1:0]   pass_idx;
  cmd_t                  op;
  key_t                  key_b;
  key_t                  key_e;
  value_t                new_val;
  key_t                  best_key;
  value_t                best_value;
  logic                  best_found;
  count_t                seen;
  count_t                removed;
  count_t                need;
  count_t                entry_count;
  logic                  pend_b;
  logic                  pend_e;
  value_t                res_value;
  status_t               res_status;
  logic                  out_valid;
  value_t                out_value;
  status_t               out_status;
  count_t                out_count;

  logic                  pass_last;
  logic                  le_lim;
  logic                  take;
  logic                  in_range;
  logic                  keep;
  logic                  tail;
  count_t                seen_next;
  count_t                removed_next;
  logic [CountBits:0]    need_sum;
  logic                  full;
  logic                  cfg_write;

  assign pass_last = (pass_idx == PassBits'(TableDepth - 1));
  assign le_lim    = (ring_out.key <= key_e);
  assign take      = ring_out.valid && le_lim && (!best_found || (ring_out.key > best_key));
  assign in_range  = ring_out.valid && le_lim && (ring_out.key >= key_b);
  assign keep      = ring_out.valid && !in_range;
  assign tail      = (key_e != '1);

  assign seen_next    = seen + count_t'(ring_out.valid);
  assign removed_next = removed + count_t'(in_range);
  assign need_sum     = {1'b0, seen_next} + (CountBits + 1)'(1)
                        + (CountBits + 1)'(tail) - {1'b0, removed_next};
  assign full         = (need_sum > (CountBits + 1)'(TableDepth));

  assign cfg_write = cfg.valid && cfg.ready;
  assign cfg.ready = 1'b1;

  assign ctl.shift      = (state == ST_SCAN) || (state == ST_WRITE);
  assign ctl.clear      = cfg_write;
  assign ctl.seed_value = cfg.initial_value;

  assign req.ready        = (state == ST_IDLE);
  assign rsp.valid        = out_valid;
  assign rsp.found_value  = out_value;
  assign rsp.status       = out_status;
  assign rsp.entries_used = out_count;

  // Kept entries pass unchanged; a freed or empty slot takes a pending insert.
  always_comb begin
    ring_in = ring_out;
    if (state == ST_WRITE && !keep) begin
      if (pend_b) begin
        ring_in = '{valid: 1'b1, key: key_b, value: new_val};
      end else if (pend_e) begin
        ring_in = '{valid: 1'b1, key: key_e, value: best_value};
      end else begin
        ring_in = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pass_idx    <= '0;
      pend_b      <= 1'b0;
      pend_e      <= 1'b0;
      entry_count <= count_t'(1);
      out_valid   <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req.valid && req.ready) begin
            op         <= cmd_t'(req.command);
            key_b      <= req.key_begin;
            key_e      <= (cmd_t'(req.command) == CMD_LOOKUP) ? req.query_key : req.key_end;
            new_val    <= req.new_value;
            pass_idx   <= '0;
            seen       <= '0;
            removed    <= '0;
            best_found <= 1'b0;
            best_key   <= '0;
            res_value  <= '0;
            if (cmd_t'(req.command) == CMD_ASSIGN && !(req.key_begin < req.key_end)) begin
              res_status <= STATUS_EMPTY;
              state      <= ST_FINISH;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          pass_idx <= pass_last ? '0 : pass_idx + PassBits'(1);
          seen     <= seen_next;
          removed  <= removed_next;
          if (take) begin
            best_found <= 1'b1;
            best_key   <= ring_out.key;
            best_value <= ring_out.value;
          end
          if (pass_last) begin
            if (op == CMD_LOOKUP) begin
              res_value  <= take ? ring_out.value : best_value;
              res_status <= STATUS_DONE;
              state      <= ST_FINISH;
            end else if (full) begin
              res_status <= STATUS_FULL;
              state      <= ST_FINISH;
            end else begin
              need   <= need_sum[CountBits-1:0];
              pend_b <= 1'b1;
              pend_e <= tail;
              state  <= ST_WRITE;
            end
          end
        end
        ST_WRITE: begin
          pass_idx <= pass_last ? '0 : pass_idx + PassBits'(1);
          if (!keep) begin
            if (pend_b) begin
              pend_b <= 1'b0;
            end else if (pend_e) begin
              pend_e <= 1'b0;
            end
          end
          if (pass_last) begin
            entry_count <= need;
            res_status  <= STATUS_DONE;
            state       <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_value  <= res_value;
            out_status <= res_status;
            out_count  <= entry_count;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cfg_write) begin
        entry_count <= count_t'(1);
      end
    end
  end

  `IRT_ASSERT_IMPL(a_count_range, 1'b1, (entry_count >= count_t'(1)) && (entry_count <= count_t'(TableDepth)), "entry count out of range")
  `IRT_ASSERT_IMPL(a_scan_count, (state == ST_SCAN) && pass_last, seen_next == entry_count, "valid cells seen in a scan differ from the entry count")
  `IRT_ASSERT_IMPL(a_write_fits, state == ST_WRITE, need <= count_t'(TableDepth), "rewrite started with a table that does not fit")
  `IRT_ASSERT_NEXT(a_inserts_placed, (state == ST_WRITE) && pass_last, !pend_b && !pend_e, "rewrite ended with an insert still pending")

endmodule

`default_nettype wire

// File: hdl/interval_range_table.sv
// Top level of the interval range table: the breakpoint ring and its sequencer.
`timescale 1ns / 1ps
`default_nettype none

//   Channel   Direction   Beat carries
//   cfg       in          initial_value; rebuilds the table as one entry
//   req       in          command, key_begin, key_end, new_value, query_key
//   rsp       out         found_value, status, entries_used
//
// The table lives in a ring of TableDepth cells that, during a scan or rewrite pass,
// rotates one place per cycle past a single compare unit in the sequencer.
// A lookup takes one pass and its result is registered in the finish state; an assign
// takes a scan pass and a rewrite pass, and an empty or reversed interval or a refused
// assign ends sooner. Reset is synchronous and leaves the table as the single entry
// (0, 0); a cfg beat rebuilds it. A result held back by rsp stalls the next item at
// its end.

module interval_range_table import irt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  irt_cfg_if.sink   cfg,
  irt_req_if.sink   req,
  irt_rsp_if.source rsp
);

  // Links of the ring: link[0] is fed by the sequencer and link[TableDepth] returns
  // to it. The cells come back to their places after a whole pass, and the table always
  // holds a valid entry at key zero: a rebuild puts one in the first cell.
  entry_t    link [TableDepth + 1];
  ring_ctl_t ring_ctl;

  // In a pass the sequencer sees one breakpoint per cycle at the end of the ring. During
  // a scan it passes each one back unchanged while it finds the last key at or below the
  // limit and counts the entries that an assign would remove. During a rewrite it drops
  // those entries and fills free slots with the new breakpoints. The table is kept as an
  // unordered set of unique keys, so no sorting shift is ever needed.
  irt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .cfg      (cfg),
    .ring_out (link[TableDepth]),
    .ring_in  (link[0]),
    .ctl      (ring_ctl)
  );

  for (genvar i = 0; i < TableDepth; i++) begin : g_cell
    irt_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ring_ctl),
      .seed (1'(i == 0)),
      .d    (link[i]),
      .q    (link[i + 1])
    );
  end

endmodule

`default_nettype wire

// File: tb/sv/tb_interval_range_table.sv
// Self-checking testbench for the interval range table: directed, fill and random phases.
`timescale 1ns / 1ps

module tb_interval_range_table;
  import irt_pkg::*;

  // One request beat as the table sees it.
  typedef struct packed {
    cmd_t   cmd;
    key_t   kb;
    key_t   ke;
    value_t nv;
    key_t   qk;
  } table_op_t;

  // One result beat.
  typedef struct packed {
    value_t  found;
    status_t status;
    count_t  used;
  } op_result_t;

  // A directed row carries its own expected result when that is obvious by inspection.
  typedef struct packed {
    table_op_t  op;
    logic       typed;
    op_result_t res;
  } directed_row_t;

  localparam key_t       KeyMax        = '1;
  localparam int         WatchdogLimit = 2000;
  // An assign needs a scan pass and a rewrite pass; allow a little on top.
  localparam int         DrainCycles   = 2 * TableDepth + 8;
  localparam int         NumPhases     = 5;
  localparam int         PhaseItems    = 68;
  localparam int         FillAssigns   = 34;
  localparam op_result_t Untyped       = '{found: '0, status: STATUS_DONE, used: '0};

  // Rows with typed = 1 compare against the result written here; the rest go to the
  // predictor. Unused fields are deliberately filled with rubbish in several rows.
  localparam int NumDirected = 24;
  localparam directed_row_t DirectedRows [NumDirected] = '{
    // Fresh table after reset: every key maps to zero.
    '{'{CMD_LOOKUP, 32'h0, 32'h0, 8'h00, 32'h0}, 1'b1, '{8'h00, STATUS_DONE, 7'd1}},
    '{'{CMD_LOOKUP, KeyMax, KeyMax, 8'hFF, KeyMax}, 1'b1, '{8'h00, STATUS_DONE, 7'd1}},
    // Empty and reversed intervals leave the table alone.
    '{'{CMD_ASSIGN, 32'h5, 32'h5, 8'h77, 32'h0}, 1'b1, '{8'h00, STATUS_EMPTY, 7'd1}},
    '{'{CMD_ASSIGN, KeyMax, 32'h0, 8'hFF, KeyMax}, 1'b1, '{8'h00, STATUS_EMPTY, 7'd1}},
    // The whole key range, maximum key included, takes the new value in one entry.
    '{'{CMD_ASSIGN, 32'h0, KeyMax, 8'hFF, 32'hA5A5A5A5}, 1'b1, '{8'h00, STATUS_DONE, 7'd1}},
    '{'{CMD_LOOKUP, 32'h0, 32'h0, 8'h00, KeyMax}, 1'b1, '{8'hFF, STATUS_DONE, 7'd1}},
    '{'{CMD_LOOKUP, KeyMax, 32'h1, 8'h12, 32'h0}, 1'b1, '{8'hFF, STATUS_DONE, 7'd1}},
    // An interval in the middle and lookups on either side of its edges.
    '{'{CMD_ASSIGN, 32'd10, 32'd20, 8'h5A, 32'h0}, 1'b0, Untyped},
    '{'{CMD_LOOKUP, 32'h0, 32'h0, 8'h00, 32'd9}, 1'b0, Untyped},
    '{'{CMD_LOOKUP, 32'h0, 32'h0, 8'h00, 32'd10}, 1'b0, Untyped},
    '{'{CMD_LOOKUP, 32'h0, 32'h0, 8'h00, 32'd19}, 1'b0, Untyped},
    '{'{CMD_LOOKUP, 32'h0, 32'h0, 8'h00, 32'd20}, 1'b0, Untyped},
    // Overwrite the breakpoint at key zero, then the top two keys.
    '{'{CMD_ASSIGN, 32'h0, 32'h1, 8'h00, KeyMax}, 1'b0, Untyped},
    '{'{CMD_ASSIGN, KeyMax - 1, KeyMax, 8'h81, 32'h0}, 1'b0, Untyped},
    '{'{CMD_LOOKUP, 32'h0, 32'h0, 8'h00, KeyMax - 1}, 1'b0, Untyped},
    '{'{CMD_LOOKUP, 32'h0, 32'h0, 8'h00, KeyMax}, 1'b0, Untyped},
    // Overlapping intervals; equal neighbours must stay as separate breakpoints.
    '{'{CMD_ASSIGN, 32'd15, 32'd30, 8'h33, 32'h0}, 1'b0, Untyped},
    '{'{CMD_ASSIGN, 32'd12, 32'd25, 8'h33, 32'h0}, 1'b0, Untyped},
    // A single key in the middle of the range, with its neighbours looked up.
    '{'{CMD_ASSIGN, 32'h80000000, 32'h80000001, 8'hAA, KeyMax}, 1'b0, Untyped},
    '{'{CMD_LOOKUP, 32'h55555555, 32'hAAAAAAAA, 8'h5A, 32'h7FFFFFFF}, 1'b0, Untyped},
    '{'{CMD_LOOKUP, 32'h0, 32'h0, 8'h00, 32'h80000000}, 1'b0, Untyped},
    '{'{CMD_LOOKUP, 32'h0, 32'h0, 8'h00, 32'h80000001}, 1'b0, Untyped},
    // Collapse everything back to one breakpoint.
    '{'{CMD_ASSIGN, 32'h0, KeyMax, 8'h00, 32'h0}, 1'b1, '{8'h00, STATUS_DONE, 7'd1}},
    '{'{CMD_LOOKUP, 32'h0, 32'h0, 8'h00, 32'h12345678}, 1'b1, '{8'h00, STATUS_DONE, 7'd1}}
  };

  logic clk;
  logic rst;

  irt_cfg_if cfg ();
  irt_req_if req ();
  irt_rsp_if rsp ();

  interval_range_table i_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (req),
    .rsp (rsp)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow copy of the breakpoint table, kept sorted by key.
  key_t   map_keys [TableDepth];
  value_t map_vals [TableDepth];
  int     map_count;

  // Results owed by the block, oldest first.
  op_result_t awaited_results [$];

  int error_count = 0;
  // When clear, neither side inserts gaps, giving back-to-back stretches.
  bit idle_on = 1'b1;

  function automatic void rebuild_map(input value_t v);
    map_keys[0] = '0;
    map_vals[0] = v;
    map_count   = 1;
  endfunction

  // Value of the last breakpoint at or below k; key zero always exists.
  function automatic value_t value_at(input key_t k);
    int hit;
    int i;
    hit = 0;
    for (i = 0; i < map_count; i++) begin
      if (map_keys[i] <= k) hit = i;
    end
    return map_vals[hit];
  endfunction

  // Applies one operation to the shadow table and returns the result it should produce.
  function automatic op_result_t apply_to_table(input table_op_t op);
    op_result_t r;
    int         lo;
    int         hi;
    int         need;
    int         n;
    int         i;
    value_t     end_val;
    bit         tail;
    key_t       nk [TableDepth];
    value_t     nv [TableDepth];
    r = Untyped;
    if (op.cmd == CMD_LOOKUP) begin
      r.found = value_at(op.qk);
    end else if (!(op.kb < op.ke)) begin
      r.status = STATUS_EMPTY;
    end else begin
      // Breakpoints lo .. hi-1 fall inside [kb, ke] and are dropped.
      lo = 0;
      while (lo < map_count && map_keys[lo] < op.kb) lo++;
      hi = lo;
      while (hi < map_count && map_keys[hi] <= op.ke) hi++;
      end_val = value_at(op.ke);
      // At the maximum key there is nothing beyond to restore.
      tail = (op.ke != KeyMax);
      need = lo + 1 + (tail ? 1 : 0) + (map_count - hi);
      if (need > TableDepth) begin
        r.status = STATUS_FULL;
      end else begin
        n = 0;
        for (i = 0; i < lo; i++) begin
          nk[n] = map_keys[i];
          nv[n] = map_vals[i];
          n++;
        end
        nk[n] = op.kb;
        nv[n] = op.nv;
        n++;
        if (tail) begin
          nk[n] = op.ke;
          nv[n] = end_val;
          n++;
        end
        for (i = hi; i < map_count; i++) begin
          nk[n] = map_keys[i];
          nv[n] = map_vals[i];
          n++;
        end
        for (i = 0; i < n; i++) begin
          map_keys[i] = nk[i];
          map_vals[i] = nv[i];
        end
        map_count = n;
      end
    end
    r.used = count_t'(map_count);
    return r;
  endfunction

  function automatic int draw_wait();
    return idle_on ? int'($urandom_range(0, 4)) : 0;
  endfunction

  // Keys are drawn from a narrow pool so that intervals overlap, from the full range so
  // that every bit toggles, from the extremes, and from next to existing breakpoints.
  function automatic key_t pick_key(input bit wide);
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (wide && sel < 70) return key_t'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 40) return key_t'($urandom_range(0, 48));
    if (sel < 60) return key_t'($urandom);
    if (sel < 72) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return key_t'(1);
        2:       return KeyMax - 1;
        default: return KeyMax;
      endcase
    end
    return map_keys[$urandom_range(0, map_count - 1)] + key_t'($urandom_range(0, 2)) - key_t'(1);
  endfunction

  // Presents one request beat after a random gap and books its expected result once the
  // beat is taken. Valid is left high on return so that a following beat with no gap
  // keeps it high without a second assignment in the same time step.
  task automatic issue_table_op(input table_op_t op, input bit typed,
                                input op_result_t typed_res);
    int         gap;
    op_result_t predicted;
    gap = draw_wait();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.command   <= op.cmd;
    req.key_begin <= op.kb;
    req.key_end   <= op.ke;
    req.new_value <= op.nv;
    req.query_key <= op.qk;
    do @(posedge clk); while (!req.ready);
    predicted = apply_to_table(op);
    awaited_results.push_back(typed ? typed_res : predicted);
  endtask

  // The register is written only once the block has nothing outstanding. Every request
  // beat yields a result, so an empty queue means the block is idle.
  task automatic load_initial_value(input value_t v);
    req.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    cfg.valid         <= 1'b1;
    cfg.initial_value <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    rebuild_map(v);
  endtask

  initial begin : stimulus
    int        i;
    int        ph;
    bit        wide;
    key_t      a;
    key_t      b;
    table_op_t op;
    rst               = 1'b1;
    req.valid         = 1'b0;
    req.command       = CMD_ASSIGN;
    req.key_begin     = '0;
    req.key_end       = '0;
    req.new_value     = '0;
    req.query_key     = '0;
    cfg.valid         = 1'b0;
    cfg.initial_value = '0;
    rebuild_map(8'h00);
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed rows, straight after reset with the register at its reset value.
    for (i = 0; i < NumDirected; i++) begin
      issue_table_op(DirectedRows[i].op, DirectedRows[i].typed, DirectedRows[i].res);
    end

    // Fill the table with disjoint intervals until assigns start being refused, then
    // look around inside it and collapse most of it again.
    load_initial_value(8'hFF);
    for (i = 0; i < FillAssigns; i++) begin
      op = '{CMD_ASSIGN, key_t'(i * 256 + 16), key_t'(i * 256 + 32), value_t'(i),
             key_t'($urandom)};
      issue_table_op(op, 1'b0, Untyped);
    end
    op = '{CMD_LOOKUP, key_t'($urandom), key_t'($urandom), value_t'($urandom), 32'h1018};
    issue_table_op(op, 1'b0, Untyped);
    op = '{CMD_LOOKUP, key_t'($urandom), key_t'($urandom), value_t'($urandom), 32'h1F20};
    issue_table_op(op, 1'b0, Untyped);
    op = '{CMD_ASSIGN, 32'h10, 32'h1800, 8'h3C, key_t'($urandom)};
    issue_table_op(op, 1'b0, Untyped);

    // Random phases, each under a fresh setting of the register. One phase runs with
    // no gaps on either side, and one leans on keys spread over the whole range so
    // that the table fills and assigns get refused.
    for (ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       load_initial_value(8'h00);
        2:       load_initial_value(8'h80);
        4:       load_initial_value(8'hFF);
        default: load_initial_value(value_t'($urandom));
      endcase
      idle_on = (ph != 2);
      wide    = (ph == 3);
      for (i = 0; i < PhaseItems; i++) begin
        a = pick_key(wide);
        b = pick_key(wide);
        // Most assigns are well formed; the rest keep whatever order they came in.
        if ($urandom_range(0, 99) >= 8) begin
          if (a > b) begin
            op.kb = b;
            b     = a;
            a     = op.kb;
          end else if (a == b) begin
            if (b == KeyMax) a = a - 1;
            else b = b + 1;
          end
        end
        op.cmd = ($urandom_range(0, 99) < 40) ? CMD_LOOKUP : CMD_ASSIGN;
        op.kb  = a;
        op.ke  = b;
        op.nv  = value_t'($urandom);
        op.qk  = pick_key(wide);
        issue_table_op(op, 1'b0, Untyped);
      end
    end
    idle_on = 1'b1;

    req.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    // Give a stray extra result time to show up.
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("interval_range_table regression: pass");
    end else begin
      $display("interval_range_table regression: fail");
    end
    $finish;
  end

  // Takes result beats with random back-pressure and checks each one against the
  // oldest outstanding expectation.
  initial begin : result_check
    op_result_t want;
    int         stall;
    rsp.ready = 1'b1;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (rsp.valid && rsp.ready) begin
        if (awaited_results.size() == 0) begin
          error_count++;
          $error("result beat with nothing outstanding: found_value %0h status %0d",
                 rsp.found_value, rsp.status);
        end else begin
          want = awaited_results.pop_front();
          if (rsp.found_value !== want.found) begin
            error_count++;
            $error("found_value: expected %0h, got %0h", want.found, rsp.found_value);
          end
          if (rsp.status !== want.status) begin
            error_count++;
            $error("status: expected %0d, got %0d", want.status, rsp.status);
          end
          if (rsp.entries_used !== want.used) begin
            error_count++;
            $error("entries_used: expected %0d, got %0d", want.used, rsp.entries_used);
          end
        end
        stall = draw_wait();
        if (stall > 0) begin
          rsp.ready <= 1'b0;
          repeat (stall) @(posedge clk);
          rsp.ready <= 1'b1;
        end
      end
    end
  end

  // Ends the run if no beat moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("interval_range_table regression: fail");
    $finish;
  end

endmodule
